### rtl/core/ezt_pkg.sv
package ezt_pkg;

    localparam int QW        = 30;
    localparam int FRAC      = 28;
    localparam int SIN_ITERS = 5;
    localparam int COS_ITERS = 6;
    localparam int SC_LAT    = 18;
    localparam int ROT_LAT   = 4;

    localparam logic [31:0] QUARTER_PI_Q = 32'd210828714;
    localparam logic [28:0] ONE_Q        = 29'd268435456;
    localparam logic [16:0] OUT_ONE      = 17'd16384;

    localparam logic [31:0] KH_TAB [8] = '{
        32'd0,          32'd421657428,  32'd843314856,  32'd1264972284,
        32'd1686629712, 32'd2108287140, 32'd2529944568, 32'd2951601996
    };

    localparam logic [28:0] SIN_M [SIN_ITERS] = '{
        29'd312361258, 29'd477218589, 29'd409044505, 29'd429496730, 29'd357913942
    };
    localparam int SIN_S [SIN_ITERS] = '{35, 35, 34, 33, 31};

    localparam logic [28:0] COS_M [COS_ITERS] = '{
        29'd520602097, 29'd381774871, 29'd306783379,
        29'd286331154, 29'd357913942, 29'd268435456
    };
    localparam int COS_S [COS_ITERS] = '{36, 35, 34, 33, 32, 29};

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
    } rot_t;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } result_t;

    // round half away from zero
    function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
        logic [QW-2:0]   ma;
        logic [QW-2:0]   mb;
        logic [2*QW-3:0] p;
        logic [QW-2:0]   m;
        ma = a[QW-1] ? (QW-1)'(-a) : a[QW-2:0];
        mb = b[QW-1] ? (QW-1)'(-b) : b[QW-2:0];
        p  = (2*QW-2)'(ma) * (2*QW-2)'(mb);
        p  = p + (2*QW-2)'(134217728);
        m  = (QW-1)'(p >> FRAC);
        return (a[QW-1] ^ b[QW-1]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [QW:0] v);
        logic [QW:0] mv;
        logic [16:0] m;
        mv = v[QW] ? (QW+1)'(-v) : v;
        m  = 17'((mv + (QW+1)'(8192)) >> 14);
        if (m > OUT_ONE)
        begin
            m = OUT_ONE;
        end
        return v[QW] ? 16'(-$signed({1'b0, m})) : 16'($signed({1'b0, m}));
    endfunction

endpackage

### rtl/core/ezt_sincos.sv
module ezt_sincos (
    input  logic                          clk,
    input  logic signed [15:0]            angle,
    output logic signed [ezt_pkg::QW-1:0] sin_q,
    output logic signed [ezt_pkg::QW-1:0] cos_q
);
    import ezt_pkg::*;

    localparam int NST = 2 * COS_ITERS;

    logic signed [32:0] xw;
    logic [31:0]        xp_reg;
    logic [31:0]        xp2_reg;
    logic [2:0]         k_next;
    logic [2:0]         k_reg;
    logic signed [32:0] r_wide;
    logic signed [28:0] r_reg;
    logic [1:0]         quad_r_reg;
    logic [27:0]        u_reg;
    logic               neg_u_reg;
    logic [1:0]         quad_u_reg;
    logic [55:0]        uu;

    logic [27:0] u_pipe_reg    [0:NST];
    logic [27:0] u2_pipe_reg   [0:NST];
    logic [28:0] tc_pipe_reg   [0:NST];
    logic [28:0] ts_pipe_reg   [0:NST];
    logic        neg_pipe_reg  [0:NST];
    logic [1:0]  quad_pipe_reg [0:NST];

    logic signed [QW-1:0] s_mag;
    logic signed [QW-1:0] sr_w;
    logic signed [QW-1:0] cr_w;
    logic signed [QW-1:0] sin_next;
    logic signed [QW-1:0] cos_next;
    logic signed [QW-1:0] sin_reg;
    logic signed [QW-1:0] cos_reg;

    assign xw = {{2{angle[15]}}, angle, 15'b0} + 33'sd1686629712;

    always_comb
    begin
        k_next = '0;
        for (int j = 1; j < 8; j++)
        begin
            if (xp_reg >= KH_TAB[j] - QUARTER_PI_Q)
            begin
                k_next = k_next + 3'd1;
            end
        end
    end

    assign r_wide = $signed({1'b0, xp2_reg}) - $signed({1'b0, KH_TAB[k_reg]});
    assign uu     = 56'(u_reg) * 56'(u_reg);

    always_ff @(posedge clk)
    begin
        xp_reg          <= xw[31:0];
        xp2_reg         <= xp_reg;
        k_reg           <= k_next;
        r_reg           <= r_wide[28:0];
        quad_r_reg      <= k_reg[1:0];
        u_reg           <= r_reg[28] ? 28'(-r_reg) : r_reg[27:0];
        neg_u_reg       <= r_reg[28];
        quad_u_reg      <= quad_r_reg;
        u_pipe_reg[0]   <= u_reg;
        u2_pipe_reg[0]  <= uu[55:28];
        tc_pipe_reg[0]  <= ONE_Q;
        ts_pipe_reg[0]  <= ONE_Q;
        neg_pipe_reg[0] <= neg_u_reg;
        quad_pipe_reg[0] <= quad_u_reg;
    end

    // each step: multiply by u2, then one minus reciprocal product
    for (genvar j = 0; j < COS_ITERS; j++)
    begin : g_iter
        localparam int P = 2 * j + 1;
        localparam int Q = 2 * j + 2;

        logic [56:0] pc_w;
        logic [56:0] ps_w;
        logic [56:0] qc_w;

        assign pc_w = 57'(u2_pipe_reg[P-1]) * 57'(tc_pipe_reg[P-1]);
        assign ps_w = (j < SIN_ITERS) ? 57'(u2_pipe_reg[P-1]) * 57'(ts_pipe_reg[P-1])
                                      : 57'(u_pipe_reg[P-1]) * 57'(ts_pipe_reg[P-1]);
        assign qc_w = 57'(tc_pipe_reg[P]) * 57'(COS_M[j]);

        always_ff @(posedge clk)
        begin
            tc_pipe_reg[P]   <= 29'(pc_w >> FRAC);
            ts_pipe_reg[P]   <= 29'(ps_w >> FRAC);
            u_pipe_reg[P]    <= u_pipe_reg[P-1];
            u2_pipe_reg[P]   <= u2_pipe_reg[P-1];
            neg_pipe_reg[P]  <= neg_pipe_reg[P-1];
            quad_pipe_reg[P] <= quad_pipe_reg[P-1];
            tc_pipe_reg[Q]   <= 29'(57'(ONE_Q) - (qc_w >> COS_S[j]));
            u_pipe_reg[Q]    <= u_pipe_reg[P];
            u2_pipe_reg[Q]   <= u2_pipe_reg[P];
            neg_pipe_reg[Q]  <= neg_pipe_reg[P];
            quad_pipe_reg[Q] <= quad_pipe_reg[P];
        end

        if (j < SIN_ITERS)
        begin : g_sin
            logic [56:0] qs_w;
            assign qs_w = 57'(ts_pipe_reg[P]) * 57'(SIN_M[j]);
            always_ff @(posedge clk)
            begin
                ts_pipe_reg[Q] <= 29'(57'(ONE_Q) - (qs_w >> SIN_S[j]));
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                ts_pipe_reg[Q] <= ts_pipe_reg[P];
            end
        end
    end

    assign s_mag = $signed({1'b0, ts_pipe_reg[NST]});
    assign sr_w  = neg_pipe_reg[NST] ? -s_mag : s_mag;
    assign cr_w  = $signed({1'b0, tc_pipe_reg[NST]});

    always_comb
    begin
        case (quad_pipe_reg[NST])
            2'd0:
            begin
                sin_next = sr_w;
                cos_next = cr_w;
            end
            2'd1:
            begin
                sin_next = cr_w;
                cos_next = -sr_w;
            end
            2'd2:
            begin
                sin_next = -sr_w;
                cos_next = -cr_w;
            end
            default:
            begin
                sin_next = -cr_w;
                cos_next = sr_w;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

### rtl/core/ezt_rotmat.sv
module ezt_rotmat (
    input  logic                          clk,
    input  logic signed [ezt_pkg::QW-1:0] sy,
    input  logic signed [ezt_pkg::QW-1:0] cy,
    input  logic signed [ezt_pkg::QW-1:0] sp,
    input  logic signed [ezt_pkg::QW-1:0] cp,
    input  logic signed [ezt_pkg::QW-1:0] sr,
    input  logic signed [ezt_pkg::QW-1:0] cr,
    output ezt_pkg::rot_t                 rot
);
    import ezt_pkg::*;

    logic signed [QW-1:0] cycp_reg, cysp_reg, sysp_reg, sycr_reg, sysr_reg;
    logic signed [QW-1:0] cycr_reg, cysr_reg, cpsr_reg, cpcr_reg, sycp_reg;
    logic signed [QW-1:0] nsp_reg, sr_reg, cr_reg;

    logic signed [QW-1:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [QW-1:0] cycp2_reg, sycr2_reg, sysr2_reg, cycr2_reg, cysr2_reg;
    logic signed [QW-1:0] cpsr2_reg, cpcr2_reg, sycp2_reg, nsp2_reg;

    logic signed [QW:0] e_reg [9];
    rot_t               rot_next;
    rot_t               rot_reg;

    always_ff @(posedge clk)
    begin
        cycp_reg <= qmul(cy, cp);
        cysp_reg <= qmul(cy, sp);
        sysp_reg <= qmul(sy, sp);
        sycr_reg <= qmul(sy, cr);
        sysr_reg <= qmul(sy, sr);
        cycr_reg <= qmul(cy, cr);
        cysr_reg <= qmul(cy, sr);
        cpsr_reg <= qmul(cp, sr);
        cpcr_reg <= qmul(cp, cr);
        sycp_reg <= qmul(sy, cp);
        nsp_reg  <= -sp;
        sr_reg   <= sr;
        cr_reg   <= cr;

        t01_reg   <= qmul(cysp_reg, sr_reg);
        t02_reg   <= qmul(cysp_reg, cr_reg);
        t11_reg   <= qmul(sysp_reg, sr_reg);
        t12_reg   <= qmul(sysp_reg, cr_reg);
        cycp2_reg <= cycp_reg;
        sycr2_reg <= sycr_reg;
        sysr2_reg <= sysr_reg;
        cycr2_reg <= cycr_reg;
        cysr2_reg <= cysr_reg;
        cpsr2_reg <= cpsr_reg;
        cpcr2_reg <= cpcr_reg;
        sycp2_reg <= sycp_reg;
        nsp2_reg  <= nsp_reg;

        e_reg[0] <= (QW+1)'(cycp2_reg);
        e_reg[1] <= (QW+1)'(t01_reg) - (QW+1)'(sycr2_reg);
        e_reg[2] <= (QW+1)'(t02_reg) + (QW+1)'(sysr2_reg);
        e_reg[3] <= (QW+1)'(sycp2_reg);
        e_reg[4] <= (QW+1)'(t11_reg) + (QW+1)'(cycr2_reg);
        e_reg[5] <= (QW+1)'(t12_reg) - (QW+1)'(cysr2_reg);
        e_reg[6] <= (QW+1)'(nsp2_reg);
        e_reg[7] <= (QW+1)'(cpsr2_reg);
        e_reg[8] <= (QW+1)'(cpcr2_reg);

        rot_reg <= rot_next;
    end

    always_comb
    begin
        rot_next.rot_00 = to_q14(e_reg[0]);
        rot_next.rot_01 = to_q14(e_reg[1]);
        rot_next.rot_02 = to_q14(e_reg[2]);
        rot_next.rot_10 = to_q14(e_reg[3]);
        rot_next.rot_11 = to_q14(e_reg[4]);
        rot_next.rot_12 = to_q14(e_reg[5]);
        rot_next.rot_20 = to_q14(e_reg[6]);
        rot_next.rot_21 = to_q14(e_reg[7]);
        rot_next.rot_22 = to_q14(e_reg[8]);
    end

    assign rot = rot_reg;

endmodule

### rtl/core/euler_zyx_pose_to_transform_core.sv
// Z-Y-X Euler pose to transform. Each pose transferred on start gives exactly one
// transform on result, with done high for that single cycle once the pose has
// passed the stages below; a new pose may be transferred every cycle and busy
// stays low. A pose takes the sine/cosine pipeline: angle reduction, then the
// six-term cosine and five-term sine series, each term a multiply stage and a
// reciprocal-divide stage, then four stages of products, sums and Q1.14 rounding.
// The receiver must take each result in the cycle that done is high.
module euler_zyx_pose_to_transform_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ezt_pkg::pose_t   pose,
    output logic             done,
    output ezt_pkg::result_t result
);
    import ezt_pkg::*;

    localparam int LAT = SC_LAT + ROT_LAT;

    logic                 accept;
    logic [LAT-1:0]       valid_reg;
    logic [LAT-1:0]       valid_next;
    logic signed [31:0]   px_reg [LAT];
    logic signed [31:0]   py_reg [LAT];
    logic signed [31:0]   pz_reg [LAT];
    logic signed [QW-1:0] sy, cy, sp, cp, sr, cr;
    rot_t                 rot;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign valid_next = {valid_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold translation alongside the rotation pipeline
    always_ff @(posedge clk)
    begin
        px_reg[0] <= pose.pos_x;
        py_reg[0] <= pose.pos_y;
        pz_reg[0] <= pose.pos_z;
        for (int i = 1; i < LAT; i++)
        begin
            px_reg[i] <= px_reg[i-1];
            py_reg[i] <= py_reg[i-1];
            pz_reg[i] <= pz_reg[i-1];
        end
    end

    ezt_sincos u_yaw (
        .clk   (clk),
        .angle (pose.yaw_angle),
        .sin_q (sy),
        .cos_q (cy)
    );

    ezt_sincos u_pitch (
        .clk   (clk),
        .angle (pose.pitch_angle),
        .sin_q (sp),
        .cos_q (cp)
    );

    ezt_sincos u_roll (
        .clk   (clk),
        .angle (pose.roll_angle),
        .sin_q (sr),
        .cos_q (cr)
    );

    ezt_rotmat u_rotmat (
        .clk (clk),
        .sy  (sy),
        .cy  (cy),
        .sp  (sp),
        .cp  (cp),
        .sr  (sr),
        .cr  (cr),
        .rot (rot)
    );

    assign done           = valid_reg[LAT-1];
    assign result.rot_00  = rot.rot_00;
    assign result.rot_01  = rot.rot_01;
    assign result.rot_02  = rot.rot_02;
    assign result.rot_10  = rot.rot_10;
    assign result.rot_11  = rot.rot_11;
    assign result.rot_12  = rot.rot_12;
    assign result.rot_20  = rot.rot_20;
    assign result.rot_21  = rot.rot_21;
    assign result.rot_22  = rot.rot_22;
    assign result.trans_x = px_reg[LAT-1];
    assign result.trans_y = py_reg[LAT-1];
    assign result.trans_z = pz_reg[LAT-1];

`ifndef ASSERT_OFF
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("done without a matching start");

    a_trans_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.trans_x == $past(pose.pos_x, LAT)
                  && result.trans_z == $past(pose.pos_z, LAT)))
        else $error("translation out of step with rotation");

    a_rot_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.rot_00 <= 16'sd16384 && result.rot_00 >= -16'sd16384
                  && result.rot_11 <= 16'sd16384 && result.rot_11 >= -16'sd16384))
        else $error("rotation entry beyond unity");
`endif

endmodule
